// ----- src/itp_pkg.sv -----
// Shared types, constants and helper functions for the infix-to-postfix converter.
// Used by every module in src; depends on nothing.
package itp_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   localparam logic [7:0] CH_OPEN  = 8'h28;  // '('
   localparam logic [7:0] CH_CLOSE = 8'h29;  // ')'
   localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
   localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
   localparam logic [7:0] CH_MUL   = 8'h2A;  // '*'
   localparam logic [7:0] CH_DIV   = 8'h2F;  // '/'
   localparam logic [7:0] CH_HASH  = 8'h23;  // '#', falls in the unknown class

   localparam logic [2:0] ST_OK              = 3'd0;
   localparam logic [2:0] ST_OVERFLOW        = 3'd1;
   localparam logic [2:0] ST_UNMATCHED_CLOSE = 3'd2;
   localparam logic [2:0] ST_UNKNOWN         = 3'd3;
   localparam logic [2:0] ST_UNMATCHED_OPEN  = 3'd4;

   typedef enum logic [2:0] {
      CLS_END,
      CLS_ALNUM,
      CLS_OPEN,
      CLS_CLOSE,
      CLS_OP,
      CLS_UNKNOWN
   } char_class_type;

   // Command broadcast to every cell of the stack row
   typedef struct packed {
      logic       push;
      logic       pop;
      logic [7:0] data;
   } stack_cmd_type;

   function automatic logic [1:0] rank_of(input logic [7:0] c);
      logic [1:0] r;
      r = 2'd0;
      if (c == CH_OPEN) r = 2'd1;
      else if (c == CH_PLUS || c == CH_MINUS) r = 2'd2;
      else if (c == CH_MUL || c == CH_DIV) r = 2'd3;
      return r;
   endfunction

   function automatic char_class_type classify(input logic [7:0] c, input logic eoe);
      char_class_type k;
      if (eoe) k = CLS_END;
      else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h30 && c <= 8'h39)) k = CLS_ALNUM;
      else if (c == CH_OPEN) k = CLS_OPEN;
      else if (c == CH_CLOSE) k = CLS_CLOSE;
      else if (rank_of(c) >= 2'd2) k = CLS_OP;
      else k = CLS_UNKNOWN;
      return k;
   endfunction

endpackage

// ----- src/itp_cell.sv -----
// One stack cell: holds a single stacked character and shifts with its neighbors.
// Depends on itp_pkg for the stack command struct.
module itp_cell
   import itp_pkg::*;
(
   input  logic          clock,
   input  stack_cmd_type cmd,
   input  logic [7:0]    above_q,   // neighbor closer to the top (or new entry)
   input  logic [7:0]    below_q,   // neighbor farther from the top
   output logic [7:0]    entry_q
);

   logic [7:0] entry_ff;
   logic [7:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.push) begin
         entry_in = above_q;
      end else if (cmd.pop) begin
         entry_in = below_q;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_q = entry_ff;

endmodule

// ----- src/itp_ctrl.sv -----
// Sequencer of the converter: latches an input word, steps pops and pushes on the
// cell row and drives the registered result word. Depends on itp_pkg.
module itp_ctrl
   import itp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_char,
   input  logic          req_end,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [7:0]    rsp_char,
   output logic          rsp_has,
   output logic          rsp_last,
   output logic [2:0]    rsp_status,
   input  logic [7:0]    top_q,
   input  logic [7:0]    second_q,
   output stack_cmd_type cmd
);

   typedef enum logic {
      S_IDLE,
      S_WORK
   } state_type;

   state_type       state_ff, state_in;
   char_class_type  cls_ff, cls_in;
   logic [7:0]      char_ff, char_in;
   logic [1:0]      rank_ff, rank_in;
   logic            open_seen_ff, open_seen_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] open_cnt_ff, open_cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_char_ff, rsp_char_in;
   logic            rsp_has_ff, rsp_has_in;
   logic            rsp_last_ff, rsp_last_in;
   logic [2:0]      rsp_status_ff, rsp_status_in;

   logic            out_free;
   logic            emit;
   logic            stack_full;
   logic            stack_empty;
   logic [1:0]      top_rank;
   logic [1:0]      second_rank;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign stack_full  = (count_ff == CNT_W'(STACK_DEPTH));
   assign stack_empty = (count_ff == '0);
   assign top_rank    = rank_of(top_q);
   assign second_rank = rank_of(second_q);

   always_comb begin
      state_in      = state_ff;
      cls_in        = cls_ff;
      char_in       = char_ff;
      rank_in       = rank_ff;
      open_seen_in  = open_seen_ff;
      count_in      = count_ff;
      open_cnt_in   = open_cnt_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      emit          = 1'b0;
      cmd.push      = 1'b0;
      cmd.pop       = 1'b0;
      cmd.data      = char_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cls_in       = classify(req_char, req_end);
               char_in      = req_char;
               rank_in      = rank_of(req_char);
               open_seen_in = (open_cnt_ff != '0);
               state_in     = S_WORK;
            end
         end
         S_WORK: begin
            if (out_free) begin
               case (cls_ff)
                  CLS_END: begin
                     if (!stack_empty) begin
                        cmd.pop = 1'b1;
                        if (top_q == CH_OPEN) begin
                           // drop silently
                        end else begin
                           emit        = 1'b1;
                           rsp_char_in = top_q;
                           rsp_has_in  = 1'b1;
                           rsp_status_in = ST_OK;
                           rsp_last_in = (count_ff == CNT_W'(1)) && !open_seen_ff;
                        end
                     end else begin
                        state_in = S_IDLE;
                        if (open_seen_ff) begin
                           emit          = 1'b1;
                           rsp_char_in   = '0;
                           rsp_has_in    = 1'b0;
                           rsp_status_in = ST_UNMATCHED_OPEN;
                           rsp_last_in   = 1'b1;
                        end
                     end
                  end
                  CLS_ALNUM: begin
                     emit          = 1'b1;
                     rsp_char_in   = char_ff;
                     rsp_has_in    = 1'b1;
                     rsp_status_in = ST_OK;
                     rsp_last_in   = 1'b1;
                     state_in      = S_IDLE;
                  end
                  CLS_OPEN, CLS_OP: begin
                     if (cls_ff == CLS_OP && !stack_empty && top_rank >= rank_ff) begin
                        // pop operator of equal or higher rank, keep going
                        emit          = 1'b1;
                        cmd.pop       = 1'b1;
                        rsp_char_in   = top_q;
                        rsp_has_in    = 1'b1;
                        rsp_status_in = ST_OK;
                        rsp_last_in   = !((count_ff > CNT_W'(1)) && (second_rank >= rank_ff));
                     end else begin
                        state_in = S_IDLE;
                        if (!stack_full) begin
                           cmd.push = 1'b1;
                        end else begin
                           emit          = 1'b1;
                           rsp_char_in   = '0;
                           rsp_has_in    = 1'b0;
                           rsp_status_in = ST_OVERFLOW;
                           rsp_last_in   = 1'b1;
                        end
                     end
                  end
                  CLS_CLOSE: begin
                     if (open_cnt_ff == '0) begin
                        emit          = 1'b1;
                        rsp_char_in   = '0;
                        rsp_has_in    = 1'b0;
                        rsp_status_in = ST_UNMATCHED_CLOSE;
                        rsp_last_in   = 1'b1;
                        state_in      = S_IDLE;
                     end else if (top_q == CH_OPEN) begin
                        cmd.pop  = 1'b1;
                        state_in = S_IDLE;
                     end else begin
                        emit          = 1'b1;
                        cmd.pop       = 1'b1;
                        rsp_char_in   = top_q;
                        rsp_has_in    = 1'b1;
                        rsp_status_in = ST_OK;
                        rsp_last_in   = (second_q == CH_OPEN);
                     end
                  end
                  default: begin
                     emit          = 1'b1;
                     rsp_char_in   = '0;
                     rsp_has_in    = 1'b0;
                     rsp_status_in = ST_UNKNOWN;
                     rsp_last_in   = 1'b1;
                     state_in      = S_IDLE;
                  end
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
         if (char_ff == CH_OPEN) open_cnt_in = open_cnt_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
         if (top_q == CH_OPEN) open_cnt_in = open_cnt_ff - CNT_W'(1);
      end

      if (emit) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         open_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         open_cnt_ff  <= open_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cls_ff        <= cls_in;
      char_ff       <= char_in;
      rank_ff       <= rank_in;
      open_seen_ff  <= open_seen_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_char   = rsp_char_ff;
   assign rsp_has    = rsp_has_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_status = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count above depth");

   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      open_cnt_ff <= count_ff)
      else $error("open count above stack count");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !stack_full)
      else $error("push into full stack");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !stack_empty)
      else $error("pop from empty stack");

   a_status_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_has_ff) |-> (rsp_status_ff != ST_OK && rsp_last_ff))
      else $error("status word without error code or last");

endmodule

// ----- src/infix_to_postfix_converter_unit.sv -----
// Top level of the infix-to-postfix converter: a row of stack cells and its sequencer.
// Depends on itp_pkg, itp_cell and itp_ctrl.
// The sequencer latches each accepted character, then works on it; every result word is
// registered before it is presented, each popped or dropped stack entry takes its own step,
// and output stalls hold the work until the word is taken. One character in flight at a time:
// a new one is accepted only once the last is done, one push or pop per cycle while output is free.
// Reset: synchronous, active high; empties the stack and drops any pending result.
module infix_to_postfix_converter_unit
   import itp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_char
   input  logic       req_tlast,   // end_of_expr
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic [3:0] rsp_tuser,   // [0] has_char, [3:1] status
   output logic       rsp_tlast    // last
);

   stack_cmd_type cmd;
   logic [7:0]    cell_q [STACK_DEPTH];
   logic          rsp_has;
   logic [2:0]    rsp_status;

   itp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_char   (req_tdata),
      .req_end    (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_char   (rsp_tdata),
      .rsp_has    (rsp_has),
      .rsp_last   (rsp_tlast),
      .rsp_status (rsp_status),
      .top_q      (cell_q[0]),
      .second_q   (cell_q[1]),
      .cmd        (cmd)
   );

   // Cell 0 is the top of the stack
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [7:0] above_q;
      logic [7:0] below_q;
      if (i == 0) begin : g_first
         assign above_q = cmd.data;
      end else begin : g_mid
         assign above_q = cell_q[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_end
         assign below_q = '0;
      end else begin : g_rest
         assign below_q = cell_q[i+1];
      end
      itp_cell u_cell (
         .clock   (clock),
         .cmd     (cmd),
         .above_q (above_q),
         .below_q (below_q),
         .entry_q (cell_q[i])
      );
   end

   assign rsp_tuser = {rsp_status, rsp_has};

endmodule
